/* sv/gcm_pkg.sv */
package gcm_pkg;

    localparam int BLOCK_W     = 128;
    localparam int HALF_W      = 64;
    localparam int BLOCK_BYTES = 16;
    localparam int CNT_W       = 5;
    localparam int CTR_W       = 32;
    localparam int AAD_W       = 61;
    localparam int TEXT_W      = 36;
    localparam int IN_DATA_W   = 264;
    localparam int OUT_DATA_W  = 160;
    localparam int OP_W        = 2;
    localparam int APB_DATA_W  = 64;
    localparam int PADDR_W     = 5;

    localparam logic [OP_W-1:0] OP_AAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ENC    = 2'd1;
    localparam logic [OP_W-1:0] OP_DEC    = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

    localparam logic [1:0] REG_HKEY_HI  = 2'd0;
    localparam logic [1:0] REG_HKEY_LO  = 2'd1;
    localparam logic [1:0] REG_NONCE_HI = 2'd2;
    localparam logic [1:0] REG_NONCE_LO = 2'd3;

    localparam logic [CTR_W-1:0] CTR_RESET = 32'd2;

    // low terms of x^128 + x^7 + x^2 + x + 1
    localparam logic [7:0] GF_POLY_TAIL = 8'h87;

endpackage

/* sv/gcm_gfmul.sv */
module gcm_gfmul import gcm_pkg::*; (
    input  logic [BLOCK_W-1:0] i_x,
    input  logic [BLOCK_W-1:0] i_h,
    output logic [BLOCK_W-1:0] o_z
);

    localparam int PROD_W = 2 * BLOCK_W - 1;
    localparam int FOLD_W = BLOCK_W + 6;
    localparam int TAIL_W = 13;

    logic [BLOCK_W-1:0] a;
    logic [BLOCK_W-1:0] b;
    logic [PROD_W-1:0]  prod;
    logic [FOLD_W-1:0]  fold;
    logic [TAIL_W-1:0]  tail;
    logic [BLOCK_W-1:0] red;

    // bit-reflected domain: first bit of the word is the x^0 term
    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            a[i] = i_x[BLOCK_W-1-i];
            b[i] = i_h[BLOCK_W-1-i];
        end
    end

    always_comb begin
        prod = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            prod = prod ^ (({{(BLOCK_W-1){1'b0}}, b} << i) & {PROD_W{a[i]}});
        end
    end

    always_comb begin
        fold = '0;
        for (int k = 0; k < 8; k++) begin
            if (GF_POLY_TAIL[k]) begin
                fold = fold ^ ({7'b0, prod[PROD_W-1:BLOCK_W]} << k);
            end
        end
        tail = '0;
        for (int k = 0; k < 8; k++) begin
            if (GF_POLY_TAIL[k]) begin
                tail = tail ^ ({7'b0, fold[FOLD_W-1:BLOCK_W]} << k);
            end
        end
        red = prod[BLOCK_W-1:0] ^ fold[BLOCK_W-1:0] ^ {{(BLOCK_W-TAIL_W){1'b0}}, tail};
    end

    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            o_z[i] = red[BLOCK_W-1-i];
        end
    end

endmodule

/* sv/gcm_ghash_ctr_core.sv */
// path from input request to result: input register, then result register
// throughput: one request per cycle without back-pressure; the hash accumulator is
// updated by one combinational gf(2^128) multiply between the input and result stages
// reset: synchronous active low, clears hash state, byte counts, counter word to two,
// key and nonce registers to zero; no clearing pass
module gcm_ghash_ctr_core import gcm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // block_high, block_low, byte_count, stream_high, stream_low, zero pad
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // op
    input  logic [OP_W-1:0]         s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // out_high, out_low, next_counter
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // is_tag
    output logic [0:0]              m_axis_tuser,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    logic [HALF_W-1:0]  r_hkey_hi;
    logic [HALF_W-1:0]  r_hkey_lo;
    logic [HALF_W-1:0]  r_nonce_hi;
    logic [CTR_W-1:0]   r_nonce_lo;

    logic               r_s1_vld;
    logic [OP_W-1:0]    r_s1_op;
    logic [BLOCK_W-1:0] r_s1_blk;
    logic [CNT_W-1:0]   r_s1_cnt;
    logic [BLOCK_W-1:0] r_s1_str;

    logic [BLOCK_W-1:0] r_accum;
    logic [CTR_W-1:0]   r_ctr;
    logic [AAD_W-1:0]   r_aad;
    logic [TEXT_W-1:0]  r_text;

    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_tag;

    logic [BLOCK_W-1:0] n_accum;
    logic [CTR_W-1:0]   n_ctr;
    logic [AAD_W-1:0]   n_aad;
    logic [TEXT_W-1:0]  n_text;
    logic [BLOCK_W-1:0] n_out;

    logic               in_acc;
    logic               s1_adv;
    logic               cfg_wr;
    logic [CNT_W-1:0]   len;
    logic               active;
    logic               is_fin;
    logic [BLOCK_W-1:0] mask;
    logic [BLOCK_W-1:0] blk_m;
    logic [BLOCK_W-1:0] txt;
    logic [BLOCK_W-1:0] lens;
    logic [BLOCK_W-1:0] hin;
    logic [BLOCK_W-1:0] prod;
    logic [AAD_W:0]     aad_sum;
    logic [TEXT_W:0]    text_sum;

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_tag;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:3])
            REG_HKEY_HI:  prdata = r_hkey_hi;
            REG_HKEY_LO:  prdata = r_hkey_lo;
            REG_NONCE_HI: prdata = r_nonce_hi;
            REG_NONCE_LO: prdata = {32'b0, r_nonce_lo};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hkey_hi  <= '0;
            r_hkey_lo  <= '0;
            r_nonce_hi <= '0;
            r_nonce_lo <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_HKEY_HI:  r_hkey_hi  <= pwdata;
                REG_HKEY_LO:  r_hkey_lo  <= pwdata;
                REG_NONCE_HI: r_nonce_hi <= pwdata;
                REG_NONCE_LO: r_nonce_lo <= pwdata[CTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op  <= s_axis_tuser;
            r_s1_blk <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            r_s1_cnt <= s_axis_tdata[132:128];
            r_s1_str <= {s_axis_tdata[196:133], s_axis_tdata[260:197]};
        end
    end

    always_comb begin
        len     = (r_s1_cnt > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES) : r_s1_cnt;
        active  = (len != '0);
        is_fin  = (r_s1_op == OP_FINISH);
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            mask[BLOCK_W-1-8*j -: 8] = (CNT_W'(j) < len) ? 8'hFF : 8'h00;
        end
        blk_m = r_s1_blk & mask;
        txt   = (blk_m ^ r_s1_str) & mask;
        lens  = {r_aad, 3'b0, {(HALF_W-TEXT_W-3){1'b0}}, r_text, 3'b0};
        case (r_s1_op)
            OP_AAD:    hin = blk_m;
            OP_ENC:    hin = txt;
            OP_DEC:    hin = blk_m;
            OP_FINISH: hin = lens;
            default:   hin = blk_m;
        endcase
    end

    gcm_gfmul u_gfmul (
        .i_x (r_accum ^ hin),
        .i_h ({r_hkey_hi, r_hkey_lo}),
        .o_z (prod)
    );

    always_comb begin
        aad_sum  = {1'b0, r_aad} + (AAD_W+1)'(len);
        text_sum = {1'b0, r_text} + (TEXT_W+1)'(len);
        n_accum  = r_accum;
        n_ctr    = r_ctr;
        n_aad    = r_aad;
        n_text   = r_text;
        n_out    = '0;
        if (is_fin) begin
            n_accum = '0;
            n_ctr   = CTR_RESET;
            n_aad   = '0;
            n_text  = '0;
            n_out   = prod ^ r_s1_str;
        end else if (active) begin
            n_accum = prod;
            if (r_s1_op == OP_AAD) begin
                n_aad = aad_sum[AAD_W] ? {AAD_W{1'b1}} : aad_sum[AAD_W-1:0];
            end else begin
                n_text = text_sum[TEXT_W] ? {TEXT_W{1'b1}} : text_sum[TEXT_W-1:0];
                n_ctr  = r_ctr + CTR_W'(1);
                n_out  = txt;
            end
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_ctr   <= CTR_RESET;
            r_aad   <= '0;
            r_text  <= '0;
        end else if (s1_adv) begin
            r_accum <= n_accum;
            r_ctr   <= n_ctr;
            r_aad   <= n_aad;
            r_text  <= n_text;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {n_ctr, n_out[HALF_W-1:0], n_out[BLOCK_W-1:HALF_W]};
            r_out_tag  <= is_fin;
        end
    end

    a_tag_ctr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_tag) |-> (r_out_data[OUT_DATA_W-1:BLOCK_W] == CTR_RESET))
        else $error("tag result does not report the restarted counter");

    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && is_fin) |=> (r_accum == '0 && r_aad == '0 && r_text == '0))
        else $error("run state not cleared after finish");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_op) && $stable(r_s1_cnt)))
        else $error("stalled input stage lost its request");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s1_adv))
        else $error("result appeared without an advancing request");

endmodule
